// ----- src/button_click_hold_detector_assert.svh -----
// Assertion macros for the button click/hold detector
`ifndef BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define BCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcd assertion failed");
// Next-cycle implication
`define BCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcd assertion failed");
`else
`define BCD_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/bcd_pkg.sv -----
package bcd_pkg;

    // Field widths
    localparam int TICK_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_GAP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_HOLD = CFG_IDX_W'(3);

    // Register reset values
    localparam logic [TICK_W-1:0] DEBOUNCE_RST  = TICK_W'(20);
    localparam logic [TICK_W-1:0] CLICK_GAP_RST = TICK_W'(300);
    localparam logic [TICK_W-1:0] HOLD_RST      = TICK_W'(1000);
    localparam logic [TICK_W-1:0] LONG_HOLD_RST = TICK_W'(3000);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Reported button state codes
    localparam logic [1:0] BSTATE_RELEASE   = 2'd0;
    localparam logic [1:0] BSTATE_PRESS     = 2'd1;
    localparam logic [1:0] BSTATE_HOLD      = 2'd2;
    localparam logic [1:0] BSTATE_LONG_HOLD = 2'd3;

    typedef enum logic [3:0] {
        MODE_RELEASE   = 4'b0001,
        MODE_PRESS     = 4'b0010,
        MODE_HOLD      = 4'b0100,
        MODE_LONG_HOLD = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] click_gap_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [TICK_W-1:0] long_hold_ticks;
    } t_cfg;

    typedef struct packed {
        logic               press_event;
        logic               release_event;
        logic               click_event;
        logic               hold_event;
        logic               long_hold_event;
        logic [COUNT_W-1:0] count_before;
        logic [COUNT_W-1:0] click_count;
        logic               debounced;
        logic [1:0]         gesture_state;
    } t_result;

endpackage

// ----- src/bcd_if.sv -----
// Service call channel
interface bcd_in_if;
    logic                      valid;
    logic                      ready;
    logic                      raw_pressed;
    logic [bcd_pkg::TICK_W-1:0] now_tick;

    modport source (output valid, raw_pressed, now_tick, input ready);
    modport sink   (input valid, raw_pressed, now_tick, output ready);
endinterface

// Result channel
interface bcd_out_if;
    logic                       valid;
    logic                       ready;
    logic                       press_event;
    logic                       release_event;
    logic                       click_event;
    logic                       hold_event;
    logic                       long_hold_event;
    logic [bcd_pkg::COUNT_W-1:0] count_before;
    logic [bcd_pkg::COUNT_W-1:0] click_count;
    logic                       debounced;
    logic [1:0]                 gesture_state;

    modport source (output valid, press_event, release_event, click_event, hold_event,
                    long_hold_event, count_before, click_count, debounced, gesture_state,
                    input ready);
    modport sink   (input valid, press_event, release_event, click_event, hold_event,
                    long_hold_event, count_before, click_count, debounced, gesture_state,
                    output ready);
endinterface

// Configuration write channel
interface bcd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bcd_pkg::CFG_IDX_W-1:0] index;
    logic [bcd_pkg::TICK_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/button_click_hold_detector.sv -----
// Path from input transfer to result valid: input register, then result register.
// One service call per cycle unless the result side stalls; the debounce and click/hold
// update is a single pass of logic between the input register and the result register.
// Reset: synchronous, active low; clears debounce, state machine and click counter,
// and loads the timeout registers with their default values.
module button_click_hold_detector (
    input  logic     i_clk,
    input  logic     i_rst_n,
    bcd_in_if.sink   i_in,
    bcd_out_if.source o_out,
    bcd_cfg_if.sink  i_cfg
);

    bcd_pkg::t_cfg              cfg;
    bcd_pkg::t_result           step_res;

    logic                       r_in_valid;
    logic                       r_raw;
    logic [bcd_pkg::TICK_W-1:0] r_now;
    logic                       r_out_valid;
    bcd_pkg::t_result           r_res;
    logic                       advance;

    // move an item into the result register when it is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    bcd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    bcd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_raw   (r_raw),
        .i_now   (r_now),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_raw <= i_in.raw_pressed;
            r_now <= i_in.now_tick;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.press_event     = r_res.press_event;
    assign o_out.release_event   = r_res.release_event;
    assign o_out.click_event     = r_res.click_event;
    assign o_out.hold_event      = r_res.hold_event;
    assign o_out.long_hold_event = r_res.long_hold_event;
    assign o_out.count_before    = r_res.count_before;
    assign o_out.click_count     = r_res.click_count;
    assign o_out.debounced       = r_res.debounced;
    assign o_out.gesture_state   = r_res.gesture_state;

endmodule

// ----- src/bcd_cfg.sv -----
module bcd_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bcd_cfg_if.sink         i_cfg,
    output bcd_pkg::t_cfg   o_cfg
);

    bcd_pkg::t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks  <= bcd_pkg::DEBOUNCE_RST;
            r_cfg.click_gap_ticks <= bcd_pkg::CLICK_GAP_RST;
            r_cfg.hold_ticks      <= bcd_pkg::HOLD_RST;
            r_cfg.long_hold_ticks <= bcd_pkg::LONG_HOLD_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bcd_pkg::CFG_DEBOUNCE:  r_cfg.debounce_ticks  <= i_cfg.data;
                bcd_pkg::CFG_CLICK_GAP: r_cfg.click_gap_ticks <= i_cfg.data;
                bcd_pkg::CFG_HOLD:      r_cfg.hold_ticks      <= i_cfg.data;
                bcd_pkg::CFG_LONG_HOLD: r_cfg.long_hold_ticks <= i_cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/bcd_step.sv -----
`include "button_click_hold_detector_assert.svh"

module bcd_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_raw,
    input  logic [bcd_pkg::TICK_W-1:0] i_now,
    input  bcd_pkg::t_cfg             i_cfg,
    output bcd_pkg::t_result          o_res
);

    logic                        r_lvl, n_lvl;
    logic [bcd_pkg::TICK_W-1:0]  r_dstamp, n_dstamp;
    logic [bcd_pkg::TICK_W-1:0]  r_pstamp, n_pstamp;
    bcd_pkg::t_mode              r_mode, n_mode;
    logic [bcd_pkg::COUNT_W-1:0] r_cnt, n_cnt;

    logic [bcd_pkg::TICK_W-1:0]  dbn_elapsed;
    logic [bcd_pkg::TICK_W-1:0]  press_elapsed;
    logic                        ev_press, ev_release, ev_click, ev_hold, ev_long;
    logic [1:0]                  bstate;

    // wrapping tick differences
    assign dbn_elapsed   = i_now - r_dstamp;
    assign press_elapsed = i_now - r_pstamp;

    // debounce
    always_comb begin
        n_lvl      = r_lvl;
        n_dstamp   = r_dstamp;
        ev_press   = 1'b0;
        ev_release = 1'b0;
        if (i_raw == r_lvl) begin
            n_dstamp = i_now;
        end else if (dbn_elapsed >= i_cfg.debounce_ticks) begin
            n_dstamp   = i_now;
            n_lvl      = i_raw;
            ev_press   = i_raw;
            ev_release = !i_raw;
        end
    end

    // click / hold state machine, driven by the new debounced level
    always_comb begin
        n_mode   = r_mode;
        n_pstamp = r_pstamp;
        n_cnt    = r_cnt;
        ev_click = 1'b0;
        ev_hold  = 1'b0;
        ev_long  = 1'b0;
        unique case (r_mode)
            bcd_pkg::MODE_RELEASE: begin
                if (!n_lvl) begin
                    if (r_cnt != '0 && press_elapsed > i_cfg.click_gap_ticks) begin
                        n_cnt = '0;
                    end
                end else begin
                    n_mode   = bcd_pkg::MODE_PRESS;
                    n_pstamp = i_now;
                end
            end
            bcd_pkg::MODE_PRESS: begin
                if (!n_lvl) begin
                    if (r_cnt != bcd_pkg::COUNT_MAX) begin
                        n_cnt = r_cnt + bcd_pkg::COUNT_W'(1);
                    end
                    n_mode   = bcd_pkg::MODE_RELEASE;
                    ev_click = 1'b1;
                end else if (press_elapsed >= i_cfg.hold_ticks) begin
                    ev_hold  = 1'b1;
                    n_pstamp = i_now;
                    n_mode   = bcd_pkg::MODE_HOLD;
                end
            end
            bcd_pkg::MODE_HOLD: begin
                if (!n_lvl) begin
                    n_mode = bcd_pkg::MODE_RELEASE;
                    n_cnt  = '0;
                end else if (press_elapsed >= i_cfg.long_hold_ticks) begin
                    ev_long  = 1'b1;
                    n_pstamp = i_now;
                    n_mode   = bcd_pkg::MODE_LONG_HOLD;
                end
            end
            bcd_pkg::MODE_LONG_HOLD: begin
                if (!n_lvl) begin
                    n_mode = bcd_pkg::MODE_RELEASE;
                    n_cnt  = '0;
                end
            end
            default: begin
                n_mode = bcd_pkg::MODE_RELEASE;
            end
        endcase
    end

    // reported state code
    always_comb begin
        unique case (n_mode)
            bcd_pkg::MODE_PRESS:     bstate = bcd_pkg::BSTATE_PRESS;
            bcd_pkg::MODE_HOLD:      bstate = bcd_pkg::BSTATE_HOLD;
            bcd_pkg::MODE_LONG_HOLD: bstate = bcd_pkg::BSTATE_LONG_HOLD;
            default:                 bstate = bcd_pkg::BSTATE_RELEASE;
        endcase
    end

    // state update, one service call per enabled cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl    <= 1'b0;
            r_dstamp <= '0;
            r_pstamp <= '0;
            r_mode   <= bcd_pkg::MODE_RELEASE;
            r_cnt    <= '0;
        end else if (i_en) begin
            r_lvl    <= n_lvl;
            r_dstamp <= n_dstamp;
            r_pstamp <= n_pstamp;
            r_mode   <= n_mode;
            r_cnt    <= n_cnt;
        end
    end

    always_comb begin
        o_res.press_event     = ev_press;
        o_res.release_event   = ev_release;
        o_res.click_event     = ev_click;
        o_res.hold_event      = ev_hold;
        o_res.long_hold_event = ev_long;
        o_res.count_before    = r_cnt;
        o_res.click_count     = n_cnt;
        o_res.debounced       = n_lvl;
        o_res.gesture_state   = bstate;
    end

    // a click only comes out of the press state
    `BCD_ASSERT_SAME(a_click_from_press, i_clk, i_rst_n,
        i_en && ev_click, r_mode == bcd_pkg::MODE_PRESS)
    // state holds between service calls
    `BCD_ASSERT_NEXT(a_idle_stable, i_clk, i_rst_n,
        !i_en, $stable(r_mode) && $stable(r_cnt) && $stable(r_lvl))
    // counter only grows, or clears
    `BCD_ASSERT_NEXT(a_cnt_monotone, i_clk, i_rst_n,
        i_en, r_cnt >= $past(r_cnt) || r_cnt == '0)
    // hold restarts the press timer at the call's tick
    `BCD_ASSERT_NEXT(a_hold_stamp, i_clk, i_rst_n,
        i_en && ev_hold, r_pstamp == $past(i_now) && r_mode == bcd_pkg::MODE_HOLD)

endmodule

// ----- tb/tb_button_click_hold_detector.sv -----
module tb_button_click_hold_detector;

    // Cycles without any transfer before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Cycles left for the result pipeline before a register write
    localparam int SETTLE_CYCLES = 4;
    // Width every result field is widened to for comparison
    localparam int FLD_W = bcd_pkg::COUNT_W;

    // Unused register indexes, both ends of the gap above the timeout registers
    localparam logic [bcd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = bcd_pkg::CFG_LONG_HOLD + 1'b1;
    localparam logic [bcd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

    // Event flags, in result field order: press, release, click, hold, long hold
    localparam logic [4:0] EV_NONE    = 5'b00000;
    localparam logic [4:0] EV_PRESS   = 5'b10000;
    localparam logic [4:0] EV_RELEASE = 5'b01000;
    localparam logic [4:0] EV_CLICK   = 5'b00100;

    // One row of the directed sequence; expectation used only when chk is set
    typedef struct packed {
        logic                        raw;
        logic [bcd_pkg::TICK_W-1:0]  tick;
        logic                        chk;
        logic [4:0]                  ev;
        logic [bcd_pkg::COUNT_W-1:0] cb;
        logic [bcd_pkg::COUNT_W-1:0] cc;
        logic                        deb;
        logic [1:0]                  st;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bcd_in_if  call_if ();
    bcd_out_if res_if ();
    bcd_cfg_if cfg_if ();

    button_click_hold_detector dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (call_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    always #2 i_clk = ~i_clk;

    // Button model state and timeout registers
    bcd_pkg::t_cfg               timeouts;
    logic                        btn_level;
    logic [bcd_pkg::TICK_W-1:0]  bounce_stamp;
    logic [bcd_pkg::TICK_W-1:0]  gesture_stamp;
    logic [1:0]                  btn_state;
    logic [bcd_pkg::COUNT_W-1:0] clicks;

    bcd_pkg::t_result            pending_results[$];
    t_dir_row                    dir_rows [0:16];
    logic [bcd_pkg::TICK_W-1:0]  tick_now = '0;
    int                          calls_sent = 0;
    int                          faults = 0;
    int                          quiet_cycles = 0;
    bit                          calm = 1'b0;

    // One service call through the debounce filter and click/hold machine
    function automatic bcd_pkg::t_result calc_button_step(
            input logic raw, input logic [bcd_pkg::TICK_W-1:0] now);
        bcd_pkg::t_result            r;
        logic [bcd_pkg::TICK_W-1:0]  since_bounce;
        logic [bcd_pkg::TICK_W-1:0]  since_press;
        r = '0;
        r.count_before = clicks;
        since_bounce = now - bounce_stamp;
        if (raw == btn_level) begin
            bounce_stamp = now;
        end else if (since_bounce >= timeouts.debounce_ticks) begin
            bounce_stamp = now;
            btn_level = raw;
            if (raw) r.press_event = 1'b1;
            else r.release_event = 1'b1;
        end
        since_press = now - gesture_stamp;
        case (btn_state)
            bcd_pkg::BSTATE_RELEASE: begin
                if (!btn_level) begin
                    if (clicks != '0 && since_press > timeouts.click_gap_ticks) clicks = '0;
                end else begin
                    btn_state = bcd_pkg::BSTATE_PRESS;
                    gesture_stamp = now;
                end
            end
            bcd_pkg::BSTATE_PRESS: begin
                if (!btn_level) begin
                    if (clicks != bcd_pkg::COUNT_MAX) clicks = clicks + 1'b1;
                    btn_state = bcd_pkg::BSTATE_RELEASE;
                    r.click_event = 1'b1;
                end else if (since_press >= timeouts.hold_ticks) begin
                    r.hold_event = 1'b1;
                    gesture_stamp = now;
                    btn_state = bcd_pkg::BSTATE_HOLD;
                end
            end
            bcd_pkg::BSTATE_HOLD: begin
                if (!btn_level) begin
                    btn_state = bcd_pkg::BSTATE_RELEASE;
                    clicks = '0;
                end else if (since_press >= timeouts.long_hold_ticks) begin
                    r.long_hold_event = 1'b1;
                    gesture_stamp = now;
                    btn_state = bcd_pkg::BSTATE_LONG_HOLD;
                end
            end
            default: begin
                if (!btn_level) begin
                    btn_state = bcd_pkg::BSTATE_RELEASE;
                    clicks = '0;
                end
            end
        endcase
        r.click_count = clicks;
        r.debounced = btn_level;
        r.gesture_state = btn_state;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [FLD_W-1:0] want,
                               input logic [FLD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endtask

    // Let the sender idle until every outstanding result has come back
    task automatic drain_results();
        call_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write, only ever issued with the block idle
    task automatic write_timeout(input logic [bcd_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [bcd_pkg::TICK_W-1:0] data);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            bcd_pkg::CFG_DEBOUNCE:  timeouts.debounce_ticks  = data;
            bcd_pkg::CFG_CLICK_GAP: timeouts.click_gap_ticks = data;
            bcd_pkg::CFG_HOLD:      timeouts.hold_ticks      = data;
            bcd_pkg::CFG_LONG_HOLD: timeouts.long_hold_ticks = data;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [bcd_pkg::TICK_W-1:0] deb,
                             input logic [bcd_pkg::TICK_W-1:0] gap,
                             input logic [bcd_pkg::TICK_W-1:0] hold,
                             input logic [bcd_pkg::TICK_W-1:0] lng);
        write_timeout(bcd_pkg::CFG_DEBOUNCE, deb);
        write_timeout(bcd_pkg::CFG_CLICK_GAP, gap);
        write_timeout(bcd_pkg::CFG_HOLD, hold);
        write_timeout(bcd_pkg::CFG_LONG_HOLD, lng);
    endtask

    // Present one service call, wait for its transfer, then log the expected result
    task automatic issue_call(input logic raw, input logic [bcd_pkg::TICK_W-1:0] tick,
                              input logic typed, input bcd_pkg::t_result typed_res);
        bcd_pkg::t_result want;
        while (!calm && $urandom_range(0, 99) < 30) begin
            call_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        call_if.valid       <= 1'b1;
        call_if.raw_pressed <= raw;
        call_if.now_tick    <= tick;
        @(posedge i_clk);
        while (call_if.ready !== 1'b1) @(posedge i_clk);
        want = calc_button_step(raw, tick);
        pending_results.push_back(typed ? typed_res : want);
        calls_sent++;
    endtask

    task automatic bounce_burst();
        repeat ($urandom_range(0, 3)) begin
            tick_now += $urandom_range(0, timeouts.debounce_ticks / 2);
            issue_call(1'($urandom_range(0, 1)), tick_now, 1'b0, '0);
        end
    endtask

    // Press with contact bounce, hold for a span around the thresholds, release
    task automatic run_gesture();
        longint unsigned span;
        int unsigned     n;
        bounce_burst();
        case ($urandom_range(0, 3))
            0: span = 64'(timeouts.debounce_ticks) + 64'($urandom_range(0, timeouts.hold_ticks));
            1: span = 64'(timeouts.debounce_ticks) + 64'(timeouts.hold_ticks)
                      + 64'($urandom_range(0, timeouts.long_hold_ticks));
            2: span = 64'(timeouts.debounce_ticks) + 64'(timeouts.hold_ticks)
                      + 64'(timeouts.long_hold_ticks) + 64'($urandom_range(0, timeouts.hold_ticks));
            default: span = 64'($urandom);
        endcase
        n = $urandom_range(2, 6);
        repeat (n) begin
            tick_now += bcd_pkg::TICK_W'(span / n + $urandom_range(0, 2));
            issue_call(1'b1, tick_now, 1'b0, '0);
        end
        bounce_burst();
        case ($urandom_range(0, 2))
            0: span = 64'(timeouts.debounce_ticks)
                      + 64'($urandom_range(0, timeouts.click_gap_ticks));
            1: span = 64'(timeouts.debounce_ticks) + 64'(timeouts.click_gap_ticks)
                      + 64'($urandom_range(1, 64));
            default: span = 64'($urandom);
        endcase
        n = $urandom_range(1, 4);
        repeat (n) begin
            tick_now += bcd_pkg::TICK_W'(span / n + $urandom_range(0, 2));
            issue_call(1'b0, tick_now, 1'b0, '0);
        end
    endtask

    // Mostly gestures, with the odd call at an arbitrary level and tick
    task automatic run_phase(input int n_calls);
        int target;
        target = calls_sent + n_calls;
        while (calls_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                tick_now = $urandom;
                issue_call(1'($urandom_range(0, 1)), tick_now, 1'b0, '0);
            end else begin
                run_gesture();
            end
        end
    endtask

    // Rapid press/release pairs, enough to run the click counter into saturation
    task automatic run_toggles(input int n_calls);
        logic lvl;
        lvl = 1'b1;
        repeat (n_calls) begin
            tick_now += $urandom_range(0, 3);
            issue_call(lvl, tick_now, 1'b0, '0);
            if ($urandom_range(0, 7) != 0) lvl = ~lvl;
        end
    endtask

    // Result side: random back-pressure unless in a calm stretch
    always @(posedge i_clk) begin
        res_if.ready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // Result checker
    always @(posedge i_clk) begin
        bcd_pkg::t_result want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no call outstanding");
                faults++;
            end else begin
                want = pending_results.pop_front();
                check_field("press_event", FLD_W'(want.press_event),
                            FLD_W'(res_if.press_event));
                check_field("release_event", FLD_W'(want.release_event),
                            FLD_W'(res_if.release_event));
                check_field("click_event", FLD_W'(want.click_event),
                            FLD_W'(res_if.click_event));
                check_field("hold_event", FLD_W'(want.hold_event),
                            FLD_W'(res_if.hold_event));
                check_field("long_hold_event", FLD_W'(want.long_hold_event),
                            FLD_W'(res_if.long_hold_event));
                check_field("count_before", want.count_before, res_if.count_before);
                check_field("click_count", want.click_count, res_if.click_count);
                check_field("debounced", FLD_W'(want.debounced), FLD_W'(res_if.debounced));
                check_field("gesture_state", FLD_W'(want.gesture_state),
                            FLD_W'(res_if.gesture_state));
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (call_if.valid && call_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("button_click_hold_detector: mismatch");
            $finish;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        call_if.valid       <= 1'b0;
        call_if.raw_pressed <= 1'b0;
        call_if.now_tick    <= '0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= bcd_pkg::CFG_DEBOUNCE;
        cfg_if.data         <= '0;

        timeouts      = '{bcd_pkg::DEBOUNCE_RST, bcd_pkg::CLICK_GAP_RST, bcd_pkg::HOLD_RST,
                          bcd_pkg::LONG_HOLD_RST};
        btn_level     = 1'b0;
        bounce_stamp  = '0;
        gesture_stamp = '0;
        btn_state     = bcd_pkg::BSTATE_RELEASE;
        clicks        = '0;

        // Directed walk at the reset timeouts: bounce, click, hold, long hold,
        // tick wrap inside a debounce window, gap clear, all-ones tick
        dir_rows = '{
            '{1'b0, 32'h0000_0000, 1'b1, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b1, 32'h0000_0005, 1'b1, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b1, 32'h0000_0019, 1'b1, EV_PRESS, 8'd0, 8'd0, 1'b1, bcd_pkg::BSTATE_PRESS},
            '{1'b0, 32'h0000_001E, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b0, 32'h0000_0032, 1'b1, EV_RELEASE | EV_CLICK, 8'd0, 8'd1, 1'b0,
              bcd_pkg::BSTATE_RELEASE},
            '{1'b1, 32'h0000_0050, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b1, 32'h0000_0438, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b1, 32'h0000_0FF0, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b0, 32'h0000_1004, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b1, 32'hFFFF_FFF0, 1'b1, EV_PRESS, 8'd0, 8'd0, 1'b1, bcd_pkg::BSTATE_PRESS},
            '{1'b0, 32'hFFFF_FFFA, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b0, 32'h0000_0004, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b0, 32'h0000_0130, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b1, 32'hFFFF_FFFF, 1'b1, EV_PRESS, 8'd0, 8'd0, 1'b1, bcd_pkg::BSTATE_PRESS},
            '{1'b1, 32'h0000_03E7, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b0, 32'h0000_03F0, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE},
            '{1'b0, 32'h0000_0400, 1'b0, EV_NONE, 8'd0, 8'd0, 1'b0, bcd_pkg::BSTATE_RELEASE}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            issue_call(dir_rows[i].raw, dir_rows[i].tick, dir_rows[i].chk,
                       {dir_rows[i].ev, dir_rows[i].cb, dir_rows[i].cc,
                        dir_rows[i].deb, dir_rows[i].st});
        end
        tick_now = 32'h0000_0400;

        // Reset timeouts, then all timeouts at zero
        run_phase(300);
        write_all('0, '0, '0, '0);
        run_phase(200);

        // Instant debounce, endless gap and hold: counter saturation, no idling
        write_all('0, '1, '1, $urandom);
        calm = 1'b1;
        run_toggles(640);
        calm = 1'b0;

        // Short timeouts; writes to unused indexes must leave them alone
        write_all($urandom_range(0, 10), $urandom_range(0, 50), $urandom_range(0, 60),
                  $urandom_range(0, 100));
        write_timeout(CFG_UNUSED_LO, $urandom);
        write_timeout(CFG_UNUSED_HI, $urandom);
        run_phase(300);

        // Full-range timeouts
        write_all($urandom, $urandom, $urandom, $urandom);
        write_timeout(bcd_pkg::CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                      $urandom);
        run_phase(150);

        // Moderate timeouts, debounce at its maximum first for a few calls
        write_timeout(bcd_pkg::CFG_DEBOUNCE, '1);
        run_phase(20);
        write_all($urandom_range(0, 200), $urandom_range(0, 2000), $urandom_range(0, 3000),
                  $urandom_range(0, 5000));
        run_phase(200);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (faults == 0) begin
            $display("button_click_hold_detector: match");
        end else begin
            $display("button_click_hold_detector: mismatch");
        end
        $finish;
    end

endmodule
